// File: rtl/core/i2cmrt_pkg.sv
package i2cmrt_pkg;

  localparam int BUF_DEPTH = 16;
  localparam int PTR_W     = 5;
  localparam int BIDX_W    = 4;
  localparam int QUEUE_DEPTH = 2;

  // Item kinds on the input channel.
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  // Configuration register indexes.
  localparam logic [2:0] ADDR_HALF_PERIOD = 3'd0;
  localparam logic [2:0] ADDR_ACK_TIMEOUT = 3'd4;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd5;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd5000;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_SB_LOW, PH_SB_HIGH, PH_ACK_A, PH_ACK_B,
    PH_RB_LOW, PH_RB_HIGH, PH_AK_LOW, PH_AK_HIGH, PH_SP_A, PH_SP_B
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       sda_in;
    logic [6:0] dev_addr;
    logic [7:0] sub_addr;
    logic [4:0] count;
    logic [7:0] write_byte;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       error;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
  } out_item_t;

  // Configuration values handed from the register file to the sequencer.
  typedef struct packed {
    logic [15:0] half_period;
    logic [15:0] ack_timeout;
  } cfg_t;

endpackage

// File: rtl/core/i2cmrt_if.sv
interface i2cmrt_in_if;
  logic                 valid;
  logic                 ready;
  i2cmrt_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cmrt_out_if;
  logic                  valid;
  logic                  ready;
  i2cmrt_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/i2cmrt_front.sv
module i2cmrt_front (
  input  logic                  clk,
  input  logic                  rst_n,
  i2cmrt_in_if.sink             in_ch,
  output logic                  q_valid,
  output i2cmrt_pkg::in_item_t  q_data,
  input  logic                  q_ready
);
  import i2cmrt_pkg::*;

  // Two-entry queue between the front and the sequencer.
  in_item_t mem_r [QUEUE_DEPTH];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  in_item_t   item;

  // Normalise the beat: clamp count so the sequencer need not.
  always_comb begin
    item = in_ch.data;
    if (in_ch.data.count > 5'(BUF_DEPTH)) begin
      item.count = 5'(BUF_DEPTH);
    end
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push    = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = mem_r[rp_r];
  assign pop     = q_valid && q_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= item;
    end
  end
endmodule

// File: rtl/core/i2cmrt_cfg.sv
module i2cmrt_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output i2cmrt_pkg::cfg_t  cfg
);
  import i2cmrt_pkg::*;

  logic [15:0] half_r, ack_r;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HALF_PERIOD_RST;
      ack_r  <= ACK_TIMEOUT_RST;
    end else if (wr) begin
      if (paddr == ADDR_HALF_PERIOD) half_r <= pwdata[15:0];
      if (paddr == ADDR_ACK_TIMEOUT) ack_r  <= pwdata[15:0];
    end
  end

  // Read back.
  always_comb begin
    prdata = 32'd0;
    if (paddr == ADDR_HALF_PERIOD) prdata = {16'd0, half_r};
    if (paddr == ADDR_ACK_TIMEOUT) prdata = {16'd0, ack_r};
  end

  assign cfg.half_period = (half_r == 16'd0) ? 16'd1 : half_r;
  assign cfg.ack_timeout = (ack_r == 16'd0) ? 16'd1 : ack_r;
endmodule

// File: rtl/core/i2cmrt_back.sv
module i2cmrt_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  i2cmrt_pkg::cfg_t      cfg,
  input  logic                  q_valid,
  input  i2cmrt_pkg::in_item_t  q_data,
  output logic                  q_ready,
  i2cmrt_out_if.source          out_ch
);
  import i2cmrt_pkg::*;

  phase_t      ph_r, ph_nxt;
  logic [BIDX_W-1:0] bit_r, bit_nxt;
  logic [15:0] dly_r, dly_nxt, rty_r, rty_nxt;
  logic [4:0]  bidx_r, bidx_nxt, lp_r, lp_nxt, tot_r, tot_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [6:0]  tgt_r, tgt_nxt;
  logic [7:0]  reg_r, reg_nxt;
  logic        dir_r, dir_nxt, scl_r, scl_nxt, sda_r, sda_nxt, err_r, err_nxt;
  logic [7:0]  buf_r [BUF_DEPTH];
  logic [7:0]  buf_q_r;
  logic        buf_wr;
  logic [4:0]  k;
  logic        step;
  out_item_t   res;
  logic        ovalid_r;
  out_item_t   odata_r;

  // Output register; take a new beat while it drains.
  assign q_ready = !ovalid_r || out_ch.ready;
  assign step    = q_valid && q_ready;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = odata_r;

  assign k      = bidx_r - 5'd1;
  assign buf_wr = step && q_data.kind == KIND_LOAD && lp_r < 5'(BUF_DEPTH);

  // Sequencer next state and result.
  always_comb begin
    ph_nxt = ph_r; bit_nxt = bit_r; dly_nxt = dly_r; rty_nxt = rty_r;
    bidx_nxt = bidx_r; lp_nxt = lp_r; tot_nxt = tot_r; sh_nxt = sh_r;
    tgt_nxt = tgt_r; reg_nxt = reg_r; dir_nxt = dir_r;
    scl_nxt = scl_r; sda_nxt = sda_r; err_nxt = err_r;
    res = '0;
    unique case (kind_t'(q_data.kind))
      KIND_LOAD: begin
        if (lp_r < 5'(BUF_DEPTH)) lp_nxt = lp_r + 5'd1;
      end
      KIND_WRITE, KIND_READ: begin
        if (ph_r == PH_IDLE) begin
          tgt_nxt = q_data.dev_addr;
          reg_nxt = q_data.sub_addr;
          tot_nxt = q_data.count;
          dir_nxt = (q_data.kind == KIND_READ);
          bidx_nxt = 5'd0; rty_nxt = 16'd0; err_nxt = 1'b0;
          ph_nxt = PH_ST_A; scl_nxt = 1'b1; sda_nxt = 1'b1;
          dly_nxt = cfg.half_period;
        end
      end
      default: begin
        if (ph_r != PH_IDLE) begin
          if (dly_r > 16'd1) begin
            dly_nxt = dly_r - 16'd1;
          end else begin
            dly_nxt = cfg.half_period;
            unique case (ph_r)
              PH_ST_A: begin
                ph_nxt = PH_ST_B; scl_nxt = 1'b1; sda_nxt = 1'b0;
              end
              PH_ST_B: begin
                sh_nxt = {tgt_r, bidx_r == 5'd2};
                bit_nxt = '0; ph_nxt = PH_SB_LOW; scl_nxt = 1'b0;
                sda_nxt = tgt_r[6];
              end
              PH_SB_LOW: begin
                ph_nxt = PH_SB_HIGH; scl_nxt = 1'b1;
              end
              PH_SB_HIGH: begin
                bit_nxt = bit_r + 4'd1;
                sh_nxt = {sh_r[6:0], 1'b0};
                if (bit_r != 4'd7) begin
                  ph_nxt = PH_SB_LOW; scl_nxt = 1'b0; sda_nxt = sh_r[6];
                end else begin
                  rty_nxt = 16'd0; ph_nxt = PH_ACK_A; scl_nxt = 1'b0; sda_nxt = 1'b1;
                end
              end
              PH_ACK_A: begin
                ph_nxt = PH_ACK_B; scl_nxt = 1'b1; sda_nxt = 1'b1;
              end
              PH_ACK_B: begin
                if (!q_data.sda_in) begin
                  bidx_nxt = bidx_r + 5'd1;
                  bit_nxt = '0; scl_nxt = 1'b0;
                  if (bidx_r == 5'd0) begin
                    sh_nxt = reg_r; ph_nxt = PH_SB_LOW; sda_nxt = reg_r[7];
                  end else if (!dir_r) begin
                    if (k < tot_r) begin
                      sh_nxt = buf_q_r; ph_nxt = PH_SB_LOW; sda_nxt = buf_q_r[7];
                    end else begin
                      ph_nxt = PH_SP_A; sda_nxt = 1'b0;
                    end
                  end else if (bidx_r == 5'd1) begin
                    ph_nxt = PH_ST_A; scl_nxt = 1'b1; sda_nxt = 1'b1;
                  end else if (tot_r == 5'd0) begin
                    ph_nxt = PH_SP_A; sda_nxt = 1'b0;
                  end else begin
                    sh_nxt = 8'd0; ph_nxt = PH_RB_LOW; sda_nxt = 1'b1;
                  end
                end else begin
                  rty_nxt = rty_r + 16'd1;
                  if (rty_nxt >= cfg.ack_timeout) begin
                    err_nxt = 1'b1; ph_nxt = PH_SP_A; scl_nxt = 1'b0; sda_nxt = 1'b0;
                  end else begin
                    scl_nxt = 1'b1; sda_nxt = 1'b1;
                  end
                end
              end
              PH_RB_LOW: begin
                sh_nxt = {sh_r[6:0], q_data.sda_in};
                ph_nxt = PH_RB_HIGH; scl_nxt = 1'b1; sda_nxt = 1'b1;
              end
              PH_RB_HIGH: begin
                bit_nxt = bit_r + 4'd1;
                if (bit_r != 4'd7) begin
                  ph_nxt = PH_RB_LOW; scl_nxt = 1'b0; sda_nxt = 1'b1;
                end else begin
                  res.read_valid = 1'b1;
                  res.read_byte = sh_r;
                  res.read_last = (bidx_r - 5'd2) >= tot_r;
                  ph_nxt = PH_AK_LOW; scl_nxt = 1'b0;
                  sda_nxt = res.read_last;
                end
              end
              PH_AK_LOW: begin
                ph_nxt = PH_AK_HIGH; scl_nxt = 1'b1;
              end
              PH_AK_HIGH: begin
                bidx_nxt = bidx_r + 5'd1;
                bit_nxt = '0;
                if ((bidx_r - 5'd2) < tot_r) begin
                  sh_nxt = 8'd0; ph_nxt = PH_RB_LOW; scl_nxt = 1'b0; sda_nxt = 1'b1;
                end else begin
                  ph_nxt = PH_SP_A; scl_nxt = 1'b0; sda_nxt = 1'b0;
                end
              end
              PH_SP_A: begin
                ph_nxt = PH_SP_B; scl_nxt = 1'b1; sda_nxt = 1'b1;
              end
              PH_SP_B: begin
                ph_nxt = PH_IDLE; dly_nxt = 16'd0;
                res.done_res = 1'b1; res.error = err_r;
                err_nxt = 1'b0; lp_nxt = 5'd0;
              end
              default: begin
                ph_nxt = PH_IDLE; scl_nxt = 1'b1; sda_nxt = 1'b1; dly_nxt = 16'd0;
              end
            endcase
          end
        end
      end
    endcase
    res.scl_out  = scl_nxt;
    res.sda_out  = sda_nxt;
    res.busy_res = (ph_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE; bit_r <= '0; dly_r <= '0; rty_r <= '0; bidx_r <= '0;
      lp_r <= '0; tot_r <= '0; sh_r <= '0; tgt_r <= '0; reg_r <= '0;
      dir_r <= 1'b0; scl_r <= 1'b1; sda_r <= 1'b1; err_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (step) begin
        ph_r <= ph_nxt; bit_r <= bit_nxt; dly_r <= dly_nxt; rty_r <= rty_nxt;
        bidx_r <= bidx_nxt; lp_r <= lp_nxt; tot_r <= tot_nxt; sh_r <= sh_nxt;
        tgt_r <= tgt_nxt; reg_r <= reg_nxt; dir_r <= dir_nxt;
        scl_r <= scl_nxt; sda_r <= sda_nxt; err_r <= err_nxt;
      end
      if (q_ready) ovalid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) odata_r <= res;
  end

  // Write buffer. The entry for the next data byte is read ahead every clock, with a
  // load to that same entry passed straight through; the byte index stays put for a
  // whole byte time before the entry is needed.
  always_ff @(posedge clk) begin
    if (buf_wr) begin
      buf_r[lp_r[3:0]] <= q_data.write_byte;
    end
    if (buf_wr && lp_r[3:0] == k[3:0]) begin
      buf_q_r <= q_data.write_byte;
    end else begin
      buf_q_r <= buf_r[k[3:0]];
    end
  end
endmodule

// File: rtl/core/i2c_master_register_transactions.sv
// I2C master for 7-bit register reads and writes, driven one time step per tick beat.
// Every input beat yields one result beat carrying the driven SCL and SDA levels and
// status. One beat is taken per clock: a two-entry queue feeds the line sequencer,
// which advances once per beat, and a result register follows it. A result beat is
// offered from the result register after the queue and the sequencer; a stalled
// result stalls the sequencer and, once the queue is full, the input. Configuration
// sits at byte 0 (half_period) and byte 4 (ack_timeout) on the APB-style port.
module i2c_master_register_transactions (
  input  logic          clk,
  input  logic          rst_n,
  i2cmrt_in_if.sink     in_ch,
  i2cmrt_out_if.source  out_ch,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);
  import i2cmrt_pkg::*;

  cfg_t     cfg;
  logic     q_valid, q_ready;
  in_item_t q_data;

  i2cmrt_cfg u_cfg (
    .clk, .rst_n, .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .pready(cfg_pready), .cfg
  );

  i2cmrt_front u_front (.clk, .rst_n, .in_ch, .q_valid, .q_data, .q_ready);

  i2cmrt_back u_back (.clk, .rst_n, .cfg, .q_valid, .q_data, .q_ready, .out_ch);
endmodule

// File: test/i2c_master_register_transactions_tb.sv
`timescale 1ns / 100ps

module i2c_master_register_transactions_tb;
  import i2cmrt_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int BEAT_TARGET = 1950;

  // Line sequencer predictor and the store of line levels still due from the block.
  class i2c_line_scoreboard;
    logic [15:0] half_period;
    logic [15:0] ack_timeout;
    phase_t      ph;
    logic [3:0]  bit_idx;
    logic [15:0] delay;
    logic [15:0] retries;
    logic [4:0]  byte_idx;
    logic [7:0]  shreg;
    logic [7:0]  wbuf [BUF_DEPTH];
    logic [4:0]  load_ptr;
    logic        rd_dir;
    logic [6:0]  target;
    logic [7:0]  regaddr;
    logic        scl;
    logic        sda;
    int          total;
    logic        err_latch;
    out_item_t   levels_due [$];
    int unsigned mismatches;

    function new();
      half_period = HALF_PERIOD_RST;
      ack_timeout = ACK_TIMEOUT_RST;
      ph = PH_IDLE;
      bit_idx = '0;
      delay = '0;
      retries = '0;
      byte_idx = '0;
      shreg = '0;
      load_ptr = '0;
      rd_dir = 1'b0;
      target = '0;
      regaddr = '0;
      scl = 1'b1;
      sda = 1'b1;
      total = 0;
      err_latch = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] addr, logic [31:0] value);
      if (addr == ADDR_HALF_PERIOD) half_period = value[15:0];
      else if (addr == ADDR_ACK_TIMEOUT) ack_timeout = value[15:0];
    endfunction

    function bit busy();
      return ph != PH_IDLE;
    endfunction

    function bit polling_ack();
      return ph == PH_ACK_B;
    endfunction

    function bit pending();
      return levels_due.size() != 0;
    endfunction

    function void enter(phase_t p, logic s, logic d);
      ph = p;
      scl = s;
      sda = d;
      delay = (half_period == 0) ? 16'd1 : half_period;
    endfunction

    function void send_byte(logic [7:0] b);
      shreg = b;
      bit_idx = '0;
      enter(PH_SB_LOW, 1'b0, b[7]);
    endfunction

    function void start_receive();
      shreg = '0;
      bit_idx = '0;
      enter(PH_RB_LOW, 1'b0, 1'b1);
    endfunction

    // Choose what follows an acknowledged byte.
    function void after_ack();
      int k;
      byte_idx++;
      k = int'(byte_idx) - 2;
      if (byte_idx == 1) begin
        send_byte(regaddr);
      end else if (!rd_dir) begin
        if (k < total && k < BUF_DEPTH) send_byte(wbuf[k[3:0]]);
        else enter(PH_SP_A, 1'b0, 1'b0);
      end else if (byte_idx == 2) begin
        enter(PH_ST_A, 1'b1, 1'b1);
      end else if (total == 0) begin
        enter(PH_SP_A, 1'b0, 1'b0);
      end else begin
        start_receive();
      end
    endfunction

    // Advance the sequencer by one accepted input beat and queue the expected levels.
    function void take_beat(in_item_t it);
      out_item_t o;
      bit last;
      o = '0;
      if (it.kind == KIND_LOAD) begin
        if (load_ptr < BUF_DEPTH) begin
          wbuf[load_ptr[3:0]] = it.write_byte;
          load_ptr++;
        end
      end else if (it.kind == KIND_WRITE || it.kind == KIND_READ) begin
        if (ph == PH_IDLE) begin
          target = it.dev_addr;
          regaddr = it.sub_addr;
          total = (it.count > BUF_DEPTH) ? BUF_DEPTH : int'(it.count);
          rd_dir = (it.kind == KIND_READ);
          byte_idx = '0;
          retries = '0;
          err_latch = 1'b0;
          enter(PH_ST_A, 1'b1, 1'b1);
        end
      end else if (ph != PH_IDLE) begin
        if (delay > 1) begin
          delay--;
        end else begin
          case (ph)
            PH_ST_A: enter(PH_ST_B, 1'b1, 1'b0);
            PH_ST_B: send_byte({target, byte_idx == 2});
            PH_SB_LOW: enter(PH_SB_HIGH, 1'b1, sda);
            PH_SB_HIGH: begin
              bit_idx++;
              shreg = shreg << 1;
              if (bit_idx < 8) begin
                enter(PH_SB_LOW, 1'b0, shreg[7]);
              end else begin
                retries = '0;
                enter(PH_ACK_A, 1'b0, 1'b1);
              end
            end
            PH_ACK_A: enter(PH_ACK_B, 1'b1, 1'b1);
            PH_ACK_B: begin
              if (!it.sda_in) begin
                scl = 1'b0;
                after_ack();
              end else begin
                retries++;
                if (retries >= ((ack_timeout == 0) ? 16'd1 : ack_timeout)) begin
                  err_latch = 1'b1;
                  enter(PH_SP_A, 1'b0, 1'b0);
                end else begin
                  enter(PH_ACK_B, 1'b1, 1'b1);
                end
              end
            end
            PH_RB_LOW: begin
              shreg = {shreg[6:0], it.sda_in};
              enter(PH_RB_HIGH, 1'b1, 1'b1);
            end
            PH_RB_HIGH: begin
              bit_idx++;
              if (bit_idx < 8) begin
                enter(PH_RB_LOW, 1'b0, 1'b1);
              end else begin
                last = (int'(byte_idx) - 2) >= total;
                o.read_valid = 1'b1;
                o.read_byte = shreg;
                o.read_last = last;
                enter(PH_AK_LOW, 1'b0, last);
              end
            end
            PH_AK_LOW: enter(PH_AK_HIGH, 1'b1, sda);
            PH_AK_HIGH: begin
              byte_idx++;
              if (int'(byte_idx) - 3 < total) start_receive();
              else enter(PH_SP_A, 1'b0, 1'b0);
            end
            PH_SP_A: enter(PH_SP_B, 1'b1, 1'b1);
            PH_SP_B: begin
              ph = PH_IDLE;
              delay = '0;
              o.done_res = 1'b1;
              o.error = err_latch;
              err_latch = 1'b0;
              load_ptr = '0;
            end
            default: begin
              ph = PH_IDLE;
              scl = 1'b1;
              sda = 1'b1;
              delay = '0;
            end
          endcase
        end
      end
      o.scl_out = scl;
      o.sda_out = sda;
      o.busy_res = (ph != PH_IDLE);
      levels_due.push_back(o);
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task compare(string field, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", field, got, want));
    endtask

    // Compare one result beat against the oldest expectation.
    task check_beat(out_item_t got);
      out_item_t want;
      if (levels_due.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        want = levels_due.pop_front();
        compare("scl_out", 8'(got.scl_out), 8'(want.scl_out));
        compare("sda_out", 8'(got.sda_out), 8'(want.sda_out));
        compare("busy_res", 8'(got.busy_res), 8'(want.busy_res));
        compare("done_res", 8'(got.done_res), 8'(want.done_res));
        compare("error", 8'(got.error), 8'(want.error));
        compare("read_byte", got.read_byte, want.read_byte);
        compare("read_valid", 8'(got.read_valid), 8'(want.read_valid));
        compare("read_last", 8'(got.read_last), 8'(want.read_last));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int unsigned cycles = 0;
  int unsigned beats_sent;
  bit          tx_calm;
  bit          rx_calm = 1'b1;

  i2c_line_scoreboard sb;

  i2cmrt_in_if  in_ch ();
  i2cmrt_out_if out_ch ();

  i2c_master_register_transactions dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL i2c_master_register_transactions");
      $finish;
    end
  end

  function automatic in_item_t noise_item();
    logic [31:0] r;
    in_item_t it;
    r = $urandom;
    it = r[$bits(in_item_t)-1:0];
    return it;
  endfunction

  // Offer one input beat after a random gap and hold it until it is taken.
  task send(in_item_t it);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.take_beat(it);
    beats_sent++;
    if ($urandom_range(0, 40) == 0) tx_calm = !tx_calm;
  endtask

  task load(logic [7:0] b);
    in_item_t it;
    it = noise_item();
    it.kind = KIND_LOAD;
    it.write_byte = b;
    send(it);
  endtask

  // Idle-time noise: ticks on a quiet bus and stray buffer loads.
  task idle_noise(int n);
    in_item_t it;
    repeat (n) begin
      it = noise_item();
      if (it.kind != KIND_LOAD) it.kind = KIND_TICK;
      send(it);
    end
  endtask

  // Register write through the configuration port, only with the block drained.
  task write_reg(logic [2:0] addr, logic [31:0] value);
    in_ch.valid <= 1'b0;
    while (sb.pending()) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.set_reg(addr, value);
  endtask

  // One complete transaction: fill the buffer for a write, start, then tick the bus
  // until the stop has gone out, answering acknowledge polls from the predicted phase.
  task run_xfer(bit rd, logic [6:0] slave, logic [7:0] regaddr, logic [4:0] cnt,
                int nack_pct, bit double_start);
    in_item_t it;
    int nload;
    if (!rd) begin
      nload = (cnt > BUF_DEPTH) ? BUF_DEPTH : int'(cnt);
      if ($urandom_range(0, 7) == 0) nload += $urandom_range(1, 3);
      repeat (nload) load(8'($urandom_range(0, 255)));
    end
    it = noise_item();
    it.kind = rd ? KIND_READ : KIND_WRITE;
    it.dev_addr = slave;
    it.sub_addr = regaddr;
    it.count = cnt;
    send(it);
    if (double_start) begin
      it = noise_item();
      it.kind = kind_t'($urandom_range(2, 3));
      send(it);
    end
    while (sb.busy()) begin
      it = noise_item();
      if ($urandom_range(0, 49) != 0) begin
        it.kind = KIND_TICK;
        if (sb.polling_ack()) it.sda_in = ($urandom_range(0, 99) < nack_pct);
      end else if (it.kind == KIND_TICK) begin
        it.kind = KIND_LOAD;
      end
      send(it);
    end
  endtask

  // Result side: accept beats with random stalls and check each one.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      int stall;
      stall = rx_calm ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_beat(out_ch.data);
      if ($urandom_range(0, 40) == 0) rx_calm = !rx_calm;
    end
  end

  initial begin
    logic [15:0] hp_set [7];
    logic [15:0] at_set [7];
    int sel;
    sb = new();
    beats_sent = 0;
    tx_calm = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at reset settings and then at the shortest half period: quiet bus,
    // extreme bytes and addresses, a start while busy, zero counts, a single read byte and an oversized count.
    idle_noise(2);
    load(8'h00);
    load(8'hFF);
    run_xfer(1'b0, 7'h7F, 8'hFF, 5'd2, 0, 1'b1);
    run_xfer(1'b1, 7'h00, 8'h00, 5'd0, 0, 1'b0);
    run_xfer(1'b0, 7'h55, 8'hAA, 5'd0, 0, 1'b0);
    run_xfer(1'b1, 7'h2A, 8'h55, 5'd1, 0, 1'b1);
    write_reg(ADDR_HALF_PERIOD, 32'd1);
    run_xfer(1'b0, 7'h33, 8'h0F, 5'd31, 0, 1'b0);
    run_xfer(1'b1, 7'h4C, 8'hF0, 5'd20, 0, 1'b0);
    // Acknowledge timeout: a target that never answers.
    write_reg(ADDR_ACK_TIMEOUT, 32'd2);
    run_xfer(1'b0, 7'h11, 8'h22, 5'd1, 100, 1'b0);
    run_xfer(1'b1, 7'h66, 8'h77, 5'd3, 100, 1'b0);

    // Random part over a rotation of settings, extremes among them.
    hp_set = '{16'd1, 16'd0, 16'd2, 16'd3, 16'd1, 16'd65535, 16'd2};
    at_set = '{16'd5000, 16'd0, 16'd3, 16'd65535, 16'd1, 16'd65535, 16'd4};
    sel = 0;
    while (beats_sent < BEAT_TARGET) begin
      write_reg(ADDR_HALF_PERIOD, {16'h0, hp_set[sel]});
      write_reg(ADDR_ACK_TIMEOUT, {16'h0, at_set[sel]});
      if (hp_set[sel] > 16'd100) begin
        // Too slow for a transfer; only a quiet bus under this setting.
        idle_noise(30);
      end else begin
        repeat (3) begin
          idle_noise($urandom_range(0, 4));
          run_xfer(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                   8'($urandom_range(0, 255)),
                   5'(($urandom_range(0, 7) == 0) ? $urandom_range(17, 31)
                                                  : $urandom_range(0, 6)),
                   (at_set[sel] < 16'd5) ? 4 : 12, $urandom_range(0, 9) == 0);
        end
      end
      sel = (sel + 1) % 7;
    end

    in_ch.valid <= 1'b0;
    while (sb.pending()) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS i2c_master_register_transactions");
    end else begin
      $display("FAIL i2c_master_register_transactions");
    end
    $finish;
  end

endmodule
